// ----- rtl/core/csc_pkg.sv -----
`timescale 1ns / 1ps
package csc_pkg;
    localparam int MAX_CIRCLES   = 1024;
    localparam int MAX_POINTS    = 1024;
    localparam int ROW_WORD_BITS = 64;
    localparam int ROW_WORDS     = (MAX_CIRCLES + ROW_WORD_BITS - 1) / ROW_WORD_BITS;
    localparam int CIRC_AW       = $clog2(MAX_CIRCLES);
    localparam int PT_AW         = $clog2(MAX_POINTS);
    localparam int WORD_AW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int BIT_AW        = $clog2(ROW_WORD_BITS);
    localparam int CTOT_W        = $clog2(MAX_CIRCLES + 1);
    localparam int PTOT_W        = $clog2(MAX_POINTS + 1);
    localparam int IDX_W         = 10;
    localparam int CNT_W         = 11;
    localparam int QDEPTH        = 2;

    typedef enum logic [1:0] {
        CMD_CIRCLE = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_CIRCLE = 2'd0,
        OP_POINT  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_ERROR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]       r;
        logic [PT_AW-1:0]  ia;
        logic [PT_AW-1:0]  ib;
    } job_t;
endpackage

// ----- rtl/core/csc_front.sv -----
`timescale 1ns / 1ps
module csc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_cmd,
    input  logic [31:0]   s_coord_x,
    input  logic [31:0]   s_coord_y,
    input  logic [30:0]   s_radius,
    input  logic [9:0]    s_first_index,
    input  logic [9:0]    s_second_index,
    output logic          q_valid,
    input  logic          q_ready,
    output csc_pkg::job_t q_job
);
    import csc_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    job_t               fifo_reg [QDEPTH];
    logic [QAW-1:0]     wptr_reg, rptr_reg;
    logic [QAW:0]       fill_reg;
    logic [PTOT_W-1:0]  ptot_reg;
    logic [CTOT_W-1:0]  ctot_reg;
    logic               push, pop, drop;
    job_t               job;

    // classify: loads over capacity and unused codes never reach the back end
    always_comb begin
        job    = '0;
        job.x  = s_coord_x;
        job.y  = s_coord_y;
        job.r  = s_radius;
        job.ia = PT_AW'(s_first_index);
        job.ib = PT_AW'(s_second_index);
        drop   = 1'b0;
        case (cmd_t'(s_cmd))
            CMD_CIRCLE: begin
                job.op = OP_CIRCLE;
                drop   = (ctot_reg == CTOT_W'(MAX_CIRCLES));
            end
            CMD_POINT: begin
                job.op = OP_POINT;
                drop   = (ptot_reg == PTOT_W'(MAX_POINTS));
            end
            CMD_QUERY: begin
                job.op = ((PTOT_W+1)'(s_first_index) >= (PTOT_W+1)'(ptot_reg)
                       || (PTOT_W+1)'(s_second_index) >= (PTOT_W+1)'(ptot_reg))
                       ? OP_ERROR : OP_QUERY;
            end
            default: drop = 1'b1;
        endcase
    end

    assign s_ready = (fill_reg != (QAW+1)'(QDEPTH));
    assign push    = s_valid && s_ready && !drop;
    assign q_valid = (fill_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_job   = fifo_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wptr_reg] <= job;
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
            ptot_reg <= '0;
            ctot_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            fill_reg <= fill_reg + (QAW+1)'(push) - (QAW+1)'(pop);
            if (push && job.op == OP_CIRCLE) ctot_reg <= ctot_reg + 1'b1;
            if (push && job.op == OP_POINT)  ptot_reg <= ptot_reg + 1'b1;
        end
    end
endmodule

// ----- rtl/core/csc_back.sv -----
`timescale 1ns / 1ps
module csc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  csc_pkg::job_t                 q_job,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [csc_pkg::CNT_W-1:0]     m_separating_count,
    output logic                          m_index_error
);
    import csc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PREAD, S_PMUL, S_PCMP, S_QRA, S_QRB, S_QACC, S_RESULT
    } state_t;

    localparam int ROWMEM = MAX_POINTS * ROW_WORDS;
    localparam int ROWAW  = $clog2(ROWMEM);

    logic [63:0] circ_mem [MAX_CIRCLES];
    logic [30:0] rad_mem  [MAX_CIRCLES];
    logic [ROW_WORD_BITS-1:0] row_mem [ROWMEM];

    state_t                 state_reg;
    job_t                   job_reg;
    logic [CTOT_W-1:0]      ctot_reg, cidx_reg;
    logic [PTOT_W-1:0]      ptot_reg;
    logic [63:0]            crd_reg;
    logic [30:0]            rrd_reg;
    logic                   out_reg;
    logic [61:0]            sx_reg, sy_reg, rr_reg;
    logic [ROW_WORD_BITS-1:0] rowacc_reg, rowa_reg, rd_reg;
    logic [WORD_AW:0]       widx_reg;
    logic [CNT_W-1:0]       cnt_reg, mcnt_reg;
    logic                   err_reg, merr_reg, mval_reg;

    logic                   ren, wen;
    logic [ROWAW-1:0]       raddr, waddr;
    logic [ROW_WORD_BITS-1:0] wdata;
    logic [CIRC_AW-1:0]     cptr;
    logic signed [32:0]     dx, dy;
    logic [32:0]            adx, ady;
    logic                   in_circle;
    logic                   last_bit;
    logic [BIT_AW-1:0]      bitpos;
    logic [CNT_W-1:0]       pc;

    assign cptr   = cidx_reg[CIRC_AW-1:0];
    assign bitpos = cidx_reg[BIT_AW-1:0];
    assign dx  = 33'(job_reg.x) - 33'(signed'(crd_reg[31:0]));
    assign dy  = 33'(job_reg.y) - 33'(signed'(crd_reg[63:32]));
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);
    assign in_circle = !out_reg && ({1'b0, sx_reg} + {1'b0, sy_reg} < {1'b0, rr_reg});
    assign last_bit  = (cidx_reg + 1'b1 == CTOT_W'(ROW_WORDS * ROW_WORD_BITS));

    always_comb begin
        pc = '0;
        for (int i = 0; i < ROW_WORD_BITS; i++) pc = pc + CNT_W'(rowa_reg[i] ^ rd_reg[i]);
    end

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = mval_reg;
    assign m_separating_count = mcnt_reg;
    assign m_index_error = merr_reg;

    // row memory port control
    always_comb begin
        ren   = 1'b0;
        raddr = '0;
        wen   = 1'b0;
        waddr = ROWAW'(ptot_reg[PT_AW-1:0]) * ROWAW'(ROW_WORDS)
              + ROWAW'(cidx_reg >> BIT_AW);
        wdata = rowacc_reg;
        if (state_reg == S_PCMP) begin
            wdata[bitpos] = in_circle;
            wen = (bitpos == BIT_AW'(ROW_WORD_BITS - 1)) || last_bit;
        end
        if (state_reg == S_QRA) begin
            ren = 1'b1;
            raddr = ROWAW'(job_reg.ia) * ROWAW'(ROW_WORDS) + ROWAW'(widx_reg);
        end
        if (state_reg == S_QRB) begin
            ren = 1'b1;
            raddr = ROWAW'(job_reg.ib) * ROWAW'(ROW_WORDS) + ROWAW'(widx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ren) rd_reg <= row_mem[raddr];
        if (wen) row_mem[waddr] <= wdata;
        crd_reg <= circ_mem[cptr];
        rrd_reg <= rad_mem[cptr];
        if (state_reg == S_IDLE && q_valid && q_job.op == OP_CIRCLE) begin
            circ_mem[ctot_reg[CIRC_AW-1:0]] <= {q_job.y, q_job.x};
            rad_mem[ctot_reg[CIRC_AW-1:0]]  <= q_job.r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ctot_reg  <= '0;
            ptot_reg  <= '0;
            mval_reg  <= 1'b0;
            cidx_reg  <= '0;
            widx_reg  <= '0;
        end else begin
            if (m_valid && m_ready) mval_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (q_valid) begin
                    job_reg  <= q_job;
                    cidx_reg <= '0;
                    widx_reg <= '0;
                    cnt_reg  <= '0;
                    rowacc_reg <= '0;
                    case (q_job.op)
                        OP_CIRCLE: ctot_reg <= ctot_reg + 1'b1;
                        OP_POINT:  state_reg <= S_PREAD;
                        OP_QUERY:  state_reg <= S_QRA;
                        default: begin
                            err_reg   <= 1'b1;
                            state_reg <= S_RESULT;
                        end
                    endcase
                end
                // walk every row bit; circles not loaded yet give zero
                S_PREAD: state_reg <= S_PMUL;
                S_PMUL: begin
                    out_reg <= (cidx_reg >= ctot_reg) || adx >= 33'(rrd_reg)
                               || ady >= 33'(rrd_reg);
                    state_reg <= S_PCMP;
                end
                S_PCMP: begin
                    if (wen) rowacc_reg <= '0;
                    else rowacc_reg[bitpos] <= in_circle;
                    if (last_bit) begin
                        ptot_reg  <= ptot_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        cidx_reg  <= cidx_reg + 1'b1;
                        state_reg <= S_PREAD;
                    end
                end
                S_QRA: state_reg <= S_QRB;
                S_QRB: begin
                    rowa_reg  <= rd_reg;
                    state_reg <= S_QACC;
                end
                S_QACC: begin
                    cnt_reg <= cnt_reg + pc;
                    if (widx_reg + 1'b1 == (WORD_AW+1)'(ROW_WORDS)) begin
                        err_reg   <= 1'b0;
                        state_reg <= S_RESULT;
                    end else begin
                        widx_reg  <= widx_reg + 1'b1;
                        state_reg <= S_QRA;
                    end
                end
                // hold until the previous result is taken, then latch the output
                S_RESULT: if (!mval_reg) begin
                    mval_reg  <= 1'b1;
                    mcnt_reg  <= cnt_reg;
                    merr_reg  <= err_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // squares registered apart from the compare
    always_ff @(posedge aclk) begin
        if (state_reg == S_PMUL) begin
            sx_reg <= 62'(adx[30:0]) * 62'(adx[30:0]);
            sy_reg <= 62'(ady[30:0]) * 62'(ady[30:0]);
            rr_reg <= 62'(rrd_reg) * 62'(rrd_reg);
        end
    end
endmodule

// ----- rtl/core/circle_separation_counter_top.sv -----
`timescale 1ns / 1ps
// channel   ports                          direction
// s_        cmd, coord, radius, indices    in
// m_        separating_count, index_error  out
// Circle load: stored from the back end's idle state. Point load: states
// PREAD, PMUL, PCMP per row bit, set by the one shared square-and-compare unit.
// Query: QRA, QRB, QACC per row word, set by the single row memory read port.
// Reset clears counts and queue only; stores hold garbage until written.
// A two-entry queue lets the front accept while the back stalls on m_ready.
module circle_separation_counter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_coord_x,
    input  logic [31:0] s_coord_y,
    input  logic [30:0] s_radius,
    input  logic [9:0]  s_first_index,
    input  logic [9:0]  s_second_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_separating_count,
    output logic        m_index_error
);
    import csc_pkg::*;

    logic q_valid, q_ready;
    job_t q_job;

    csc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_coord_x, .s_coord_y,
        .s_radius, .s_first_index, .s_second_index, .q_valid, .q_ready, .q_job
    );

    csc_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_job, .m_valid, .m_ready,
        .m_separating_count, .m_index_error
    );
endmodule

// ----- rtl/core/csc_checker.sv -----
`timescale 1ns / 1ps
module csc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [10:0] m_separating_count,
    input logic        m_index_error
);
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_separating_count == 11'd0)
        else $error("error result with nonzero count");
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_separating_count <= 11'd1024)
        else $error("count over capacity");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_separating_count))
        else $error("result dropped while stalled");
endmodule

bind circle_separation_counter_top csc_checker u_csc_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_separating_count, .m_index_error
);

// ----- tb/sv/tb_circle_separation_counter_top.sv -----
`timescale 1ns / 1ps
module tb_circle_separation_counter_top;
    import csc_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] r;
        logic [9:0]  ia;
        logic [9:0]  ib;
    } request_t;

    typedef struct {
        logic [10:0] count;
        logic        err;
    } separation_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [31:0] s_coord_x;
    logic [31:0] s_coord_y;
    logic [30:0] s_radius;
    logic [9:0]  s_first_index;
    logic [9:0]  s_second_index;
    logic        m_valid;
    logic        m_ready;
    logic [10:0] m_separating_count;
    logic        m_index_error;

    circle_separation_counter_top dut (.*);

    request_t    pending_requests[$];
    separation_t expected_separations[$];
    int          failures = 0;
    int          gen_circles = 0;
    int          gen_points = 0;
    bit          stimulus_done = 0;

    // predictor state
    logic signed [31:0] circ_x[MAX_CIRCLES];
    logic signed [31:0] circ_y[MAX_CIRCLES];
    logic [30:0]        circ_r[MAX_CIRCLES];
    logic [MAX_CIRCLES-1:0] rows[MAX_POINTS];
    int circle_count = 0;
    int point_count = 0;

    int s_gap = 0;
    int m_gap = 0;
    bit s_calm = 0;
    bit m_calm = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap(bit calm);
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic bit point_inside(logic signed [31:0] px, logic signed [31:0] py,
                                        int c);
        longint dx, dy;
        logic [65:0] ax, ay, rr;
        dx = longint'(px) - longint'(circ_x[c]);
        dy = longint'(py) - longint'(circ_y[c]);
        ax = (dx < 0) ? 66'(-dx) : 66'(dx);
        ay = (dy < 0) ? 66'(-dy) : 66'(dy);
        rr = 66'(circ_r[c]);
        return (ax * ax + ay * ay) < (rr * rr);
    endfunction

    task automatic apply_request(request_t q);
        separation_t e;
        case (q.cmd)
            CMD_CIRCLE: begin
                if (circle_count < MAX_CIRCLES) begin
                    circ_x[circle_count] = q.x;
                    circ_y[circle_count] = q.y;
                    circ_r[circle_count] = q.r;
                    circle_count++;
                end
            end
            CMD_POINT: begin
                if (point_count < MAX_POINTS) begin
                    rows[point_count] = '0;
                    for (int c = 0; c < circle_count; c++)
                        rows[point_count][c] = point_inside(q.x, q.y, c);
                    point_count++;
                end
            end
            CMD_QUERY: begin
                if (q.ia >= point_count || q.ib >= point_count) begin
                    e.count = '0;
                    e.err = 1'b1;
                end else begin
                    e.count = 11'($countones(rows[q.ia] ^ rows[q.ib]));
                    e.err = 1'b0;
                end
                expected_separations = {expected_separations, e};
            end
            default: ;
        endcase
    endtask

    task automatic add_request(cmd_t cmd, logic [31:0] x, logic [31:0] y, logic [30:0] r,
                               logic [9:0] ia, logic [9:0] ib);
        request_t q;
        q.cmd = cmd; q.x = x; q.y = y; q.r = r; q.ia = ia; q.ib = ib;
        if (cmd == CMD_CIRCLE) gen_circles++;
        if (cmd == CMD_POINT) gen_points++;
        pending_requests = {pending_requests, q};
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 2000)) - 1000);
    endfunction

    function automatic logic [30:0] rand_radius();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 31'($urandom);
        if (p == 1) return '0;
        return 31'($urandom_range(0, 1500));
    endfunction

    function automatic logic [9:0] rand_index();
        if ($urandom_range(0, 9) == 0) return 10'($urandom);
        return 10'($urandom_range(0, gen_points + 1));
    endfunction

    task automatic add_random(cmd_t cmd);
        add_request(cmd, rand_coord(), rand_coord(), rand_radius(), rand_index(),
                    rand_index());
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_cmd <= CMD_NONE;
            s_coord_x <= '0;
            s_coord_y <= '0;
            s_radius <= '0;
            s_first_index <= '0;
            s_second_index <= '0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request('{cmd_t'(s_cmd), s_coord_x, s_coord_y, s_radius,
                                s_first_index, s_second_index});
                s_gap = pick_gap(s_calm);
                if ($urandom_range(0, 199) == 0) s_calm = ~s_calm;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    request_t q;
                    q = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= q.cmd;
                    s_coord_x <= q.x;
                    s_coord_y <= q.y;
                    s_radius <= q.r;
                    s_first_index <= q.ia;
                    s_second_index <= q.ib;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_separations.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual count %0d err %0b",
                             $time, m_separating_count, m_index_error);
                    failures++;
                end else begin
                    separation_t e;
                    e = expected_separations.pop_front();
                    if (m_separating_count !== e.count) begin
                        $display("%0t: separating_count mismatch: expected %0d, actual %0d",
                                 $time, e.count, m_separating_count);
                        failures++;
                    end
                    if (m_index_error !== e.err) begin
                        $display("%0t: index_error mismatch: expected %0b, actual %0b",
                                 $time, e.err, m_index_error);
                        failures++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) m_gap = pick_gap(m_calm);
                if ($urandom_range(0, 299) == 0) m_calm = ~m_calm;
            end
        end
    end

    initial begin
        #200ms;
        $display("tb_circle_separation_counter_top: FAIL");
        $finish;
    end

    initial begin
        int p;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_cmd = CMD_NONE;
        s_coord_x = '0;
        s_coord_y = '0;
        s_radius = '0;
        s_first_index = '0;
        s_second_index = '0;

        // query with no points stored, unused selector
        add_request(CMD_QUERY, 0, 0, 0, 0, 0);
        add_request(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 10'h3FF, 10'h3FF);
        add_request(CMD_CIRCLE, 0, 0, 0, 0, 0);
        add_request(CMD_CIRCLE, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0);
        add_request(CMD_CIRCLE, 0, 0, 5, 0, 0);
        add_request(CMD_CIRCLE, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 0, 0);
        add_request(CMD_CIRCLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0);
        add_request(CMD_POINT, 0, 0, 0, 0, 0);
        add_request(CMD_POINT, 3, 4, 0, 0, 0);
        add_request(CMD_POINT, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        add_request(CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        add_request(CMD_POINT, 3, 3, 0, 0, 0);
        add_request(CMD_QUERY, 0, 0, 0, 0, 1);
        add_request(CMD_QUERY, 0, 0, 0, 2, 3);
        add_request(CMD_QUERY, 0, 0, 0, 0, 0);
        add_request(CMD_QUERY, 0, 0, 0, 4, 1);
        add_request(CMD_QUERY, 0, 0, 0, 5, 0);
        add_request(CMD_QUERY, 0, 0, 0, 0, 10'h3FF);
        // circle after points leaves old rows alone
        add_request(CMD_CIRCLE, 0, 0, 100, 0, 0);
        add_request(CMD_POINT, 1, 1, 0, 0, 0);
        add_request(CMD_QUERY, 0, 0, 0, 0, 5);
        add_request(CMD_QUERY, 0, 0, 0, 4, 5);

        for (int i = 0; i < 20; i++) begin
            p = $urandom_range(0, 99);
            if (p < 30) add_random(CMD_CIRCLE);
            else if (p < 45) add_random(CMD_POINT);
            else if (p < 95) add_random(CMD_QUERY);
            else add_random(CMD_NONE);
        end
        // overfill the circle store, then the point store
        while (gen_circles < MAX_CIRCLES + 3) add_random(CMD_CIRCLE);
        while (gen_points < MAX_POINTS + 3) begin
            add_random(CMD_POINT);
            if (gen_points % 32 == 0) add_random(CMD_QUERY);
        end
        for (int i = 0; i < 10; i++)
            add_request(CMD_QUERY, 0, 0, 0, 10'($urandom), 10'($urandom));
        add_request(CMD_QUERY, 0, 0, 0, 10'h3FF, 10'h000);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() > 0 || s_valid) @(posedge aclk);
        while (expected_separations.size() > 0) @(posedge aclk);
        repeat (4000) @(posedge aclk);
        if (failures == 0 && expected_separations.size() == 0) begin
            $display("tb_circle_separation_counter_top: PASS");
        end else begin
            $display("tb_circle_separation_counter_top: FAIL");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/csc_pkg.sv
rtl/core/csc_front.sv
rtl/core/csc_back.sv
rtl/core/circle_separation_counter_top.sv
rtl/core/csc_checker.sv
tb/sv/tb_circle_separation_counter_top.sv
